FILE: rtl/sgpe_pkg.sv
// Shared types and constants for the sphere grid point enumerator.
package sgpe_pkg;

  localparam int unsigned MAX_STEPS = 255;
  localparam int STEPS_W = 8;
  localparam int COORD_W = 9;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SYM_FULL   = 2'd0,
    SYM_HALF   = 2'd1,
    SYM_OCTANT = 2'd2
  } sym_t;

  typedef enum logic {
    CFG_GRID_STEPS = 1'b0,
    CFG_SYMMETRY   = 1'b1
  } cfg_index_t;

endpackage

FILE: rtl/sphere_grid_point_enumerator.sv
// Top level of the sphere grid point enumerator: scan state, cell test and result register.
//
// Each input transfer examines one cell of a cubic grid of (grid_steps+1)^3
// cells, x outer, y middle, z inner. A transfer with restart high begins a new
// scan at the first cell. A cell inside the sphere and kept by the symmetry
// mode gives one output transfer of kind point with its half-step coordinates.
// The transfer after the last cell gives the done or empty report and ends the
// scan. Cells that are dropped, and transfers while idle, give no output.
// The cell test (three squares, a sum and a compare) sits between the scan
// state registers and the output register, so a result is registered in the cycle
// after its input transfer and one input transfer can be taken in every cycle.
// An output waiting in the output register does not block the input as long
// as the receiver takes it in the same cycle; while the receiver stalls, the
// input is held off. The configuration channel is always ready and should be
// written only while no scan is running. Reset clears the scan state, empties
// the output register and sets grid_steps to 1 and symmetry_mode to full.
module sphere_grid_point_enumerator
  import sgpe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       restart,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 kind,
  output logic signed [COORD_W-1:0]  x_half_steps,
  output logic signed [COORD_W-1:0]  y_half_steps,
  output logic signed [COORD_W-1:0]  z_half_steps
);

  logic [STEPS_W-1:0] grid_steps;
  logic [1:0]         symmetry_mode;

  logic [STEPS_W-1:0] outer_index, middle_index, inner_index;
  logic [STEPS_W-1:0] outer_index_next, middle_index_next, inner_index_next;
  logic scan_active, scan_active_next;
  logic any_point_found, any_point_found_next;
  logic cells_exhausted, cells_exhausted_next;
  logic out_valid_next;

  logic in_xfer;
  logic [STEPS_W-1:0] s;
  logic [STEPS_W-1:0] i_cur, j_cur, k_cur;
  logic cur_exhausted, cur_found;
  logic signed [COORD_W:0] x_cur, y_cur, z_cur;
  logic [COORD_W-1:0] x_abs, y_abs, z_abs;
  logic [2*COORD_W-1:0] x_sq, y_sq, z_sq;
  logic [2*COORD_W+1:0] sum_sq;
  logic [2*STEPS_W-1:0] lim_sq;
  logic keep, emit;
  kind_t kind_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;

  assign s = (32'(grid_steps) > MAX_STEPS) ? STEPS_W'(MAX_STEPS) : grid_steps;

  always_comb begin
    i_cur = restart ? '0 : outer_index;
    j_cur = restart ? '0 : middle_index;
    k_cur = restart ? '0 : inner_index;
    cur_exhausted = restart ? 1'b0 : cells_exhausted;
    cur_found     = restart ? 1'b0 : any_point_found;

    x_cur = $signed({1'b0, i_cur, 1'b0}) - $signed({2'b00, s});
    y_cur = $signed({1'b0, j_cur, 1'b0}) - $signed({2'b00, s});
    z_cur = $signed({1'b0, k_cur, 1'b0}) - $signed({2'b00, s});
    x_abs = x_cur[COORD_W] ? COORD_W'(-x_cur) : x_cur[COORD_W-1:0];
    y_abs = y_cur[COORD_W] ? COORD_W'(-y_cur) : y_cur[COORD_W-1:0];
    z_abs = z_cur[COORD_W] ? COORD_W'(-z_cur) : z_cur[COORD_W-1:0];
    x_sq = x_abs * x_abs;
    y_sq = y_abs * y_abs;
    z_sq = z_abs * z_abs;
    sum_sq = (2*COORD_W+2)'(x_sq) + (2*COORD_W+2)'(y_sq) + (2*COORD_W+2)'(z_sq);
    lim_sq = s * s;

    keep = sum_sq <= (2*COORD_W+2)'(lim_sq);
    if (symmetry_mode != SYM_FULL && z_cur[COORD_W]) begin
      keep = 1'b0;
    end
    if (symmetry_mode[1] && (x_cur[COORD_W] || y_cur[COORD_W])) begin
      keep = 1'b0;
    end

    outer_index_next     = outer_index;
    middle_index_next    = middle_index;
    inner_index_next     = inner_index;
    scan_active_next     = scan_active;
    any_point_found_next = any_point_found;
    cells_exhausted_next = cells_exhausted;
    emit      = 1'b0;
    kind_next = KIND_POINT;

    if (in_xfer && (restart || scan_active)) begin
      scan_active_next     = 1'b1;
      any_point_found_next = cur_found;
      cells_exhausted_next = cur_exhausted;
      outer_index_next     = i_cur;
      middle_index_next    = j_cur;
      inner_index_next     = k_cur;
      if (cur_exhausted) begin
        emit                 = 1'b1;
        kind_next            = cur_found ? KIND_DONE : KIND_EMPTY;
        scan_active_next     = 1'b0;
        cells_exhausted_next = 1'b0;
      end else begin
        if (k_cur >= s) begin
          inner_index_next = '0;
          if (j_cur >= s) begin
            middle_index_next = '0;
            if (i_cur >= s) begin
              outer_index_next     = '0;
              cells_exhausted_next = 1'b1;
            end else begin
              outer_index_next = i_cur + 1'b1;
            end
          end else begin
            middle_index_next = j_cur + 1'b1;
          end
        end else begin
          inner_index_next = k_cur + 1'b1;
        end
        if (keep) begin
          emit                 = 1'b1;
          any_point_found_next = 1'b1;
        end
      end
    end

    out_valid_next = out_valid && !out_ready;
    if (emit) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_steps      <= STEPS_W'(1);
      symmetry_mode   <= SYM_FULL;
      outer_index     <= '0;
      middle_index    <= '0;
      inner_index     <= '0;
      scan_active     <= 1'b0;
      any_point_found <= 1'b0;
      cells_exhausted <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_STEPS: grid_steps    <= cfg_data;
          CFG_SYMMETRY:   symmetry_mode <= cfg_data[1:0];
          default: ;
        endcase
      end
      outer_index     <= outer_index_next;
      middle_index    <= middle_index_next;
      inner_index     <= inner_index_next;
      scan_active     <= scan_active_next;
      any_point_found <= any_point_found_next;
      cells_exhausted <= cells_exhausted_next;
      out_valid       <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind <= kind_next;
      if (kind_next == KIND_POINT) begin
        x_half_steps <= x_cur[COORD_W-1:0];
        y_half_steps <= y_cur[COORD_W-1:0];
        z_half_steps <= z_cur[COORD_W-1:0];
      end else begin
        x_half_steps <= '0;
        y_half_steps <= '0;
        z_half_steps <= '0;
      end
    end
  end

endmodule

FILE: rtl/sgpe_checker.sv
// Port-level assertions for the sphere grid point enumerator and their binding.
module sgpe_checker
  import sgpe_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                kind,
  input logic signed [COORD_W-1:0] x_half_steps,
  input logic signed [COORD_W-1:0] y_half_steps,
  input logic signed [COORD_W-1:0] z_half_steps
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(x_half_steps)
      && $stable(y_half_steps) && $stable(z_half_steps))
    else $error("Stalled output transfer changed.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid right after reset.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input held off with an empty output register.");

  a_report_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_POINT |->
      x_half_steps == '0 && y_half_steps == '0 && z_half_steps == '0)
    else $error("End report carries nonzero coordinates.");

  a_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_POINT |->
      x_half_steps[0] == y_half_steps[0] && y_half_steps[0] == z_half_steps[0])
    else $error("Point coordinates differ in parity.");

endmodule

bind sphere_grid_point_enumerator sgpe_checker u_sgpe_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .x_half_steps (x_half_steps),
  .y_half_steps (y_half_steps),
  .z_half_steps (z_half_steps)
);

FILE: verif/testbench.sv
// Self-checking testbench for the sphere grid point enumerator: directed, pressure and random scans.
`timescale 1ns / 100ps

module testbench
  import sgpe_pkg::*;
();

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [1:0] SYM_UNUSED = 2'd3;

  typedef struct packed {
    kind_t                      kind;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } grid_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_GRID_STEPS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic signed [COORD_W-1:0] x_half_steps;
  logic signed [COORD_W-1:0] y_half_steps;
  logic signed [COORD_W-1:0] z_half_steps;

  grid_result_t expected_cells[$];
  int mismatches = 0;
  int cycle_count = 0;
  int transfers_in = 0;
  int points_seen = 0;
  int done_seen = 0;
  int empty_seen = 0;
  int send_idle_pct = 36;
  int recv_idle_pct = 75;
  int hold_cycles = 0;

  // Predicted configuration and scan state.
  logic [STEPS_W-1:0] grid_steps_now = 8'd1;
  logic [1:0] symmetry_now = SYM_FULL;
  logic [STEPS_W-1:0] cell_x = '0;
  logic [STEPS_W-1:0] cell_y = '0;
  logic [STEPS_W-1:0] cell_z = '0;
  bit scanning = 1'b0;
  bit found_point = 1'b0;
  bit cells_done = 1'b0;

  sphere_grid_point_enumerator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .restart(restart),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .x_half_steps(x_half_steps), .y_half_steps(y_half_steps), .z_half_steps(z_half_steps)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic predict_cell(input bit new_scan);
    int s;
    int x;
    int y;
    int z;
    bit keep;
    grid_result_t r;
    s = (grid_steps_now > MAX_STEPS) ? MAX_STEPS : int'(grid_steps_now);
    if (new_scan) begin
      cell_x = '0;
      cell_y = '0;
      cell_z = '0;
      scanning = 1'b1;
      found_point = 1'b0;
      cells_done = 1'b0;
    end else if (!scanning) begin
      return;
    end
    if (cells_done) begin
      r.kind = found_point ? KIND_DONE : KIND_EMPTY;
      r.x = '0;
      r.y = '0;
      r.z = '0;
      expected_cells = {expected_cells, r};
      scanning = 1'b0;
      cells_done = 1'b0;
      return;
    end
    x = 2 * int'(cell_x) - s;
    y = 2 * int'(cell_y) - s;
    z = 2 * int'(cell_z) - s;
    keep = (x * x + y * y + z * z) <= s * s;
    if (symmetry_now != SYM_FULL && z < 0) keep = 1'b0;
    if (symmetry_now[1] && (x < 0 || y < 0)) keep = 1'b0;
    if (cell_z >= s) begin
      cell_z = '0;
      if (cell_y >= s) begin
        cell_y = '0;
        if (cell_x >= s) begin
          cell_x = '0;
          cells_done = 1'b1;
        end else begin
          cell_x++;
        end
      end else begin
        cell_y++;
      end
    end else begin
      cell_z++;
    end
    if (keep) begin
      found_point = 1'b1;
      r.kind = KIND_POINT;
      r.x = x[COORD_W-1:0];
      r.y = y[COORD_W-1:0];
      r.z = z[COORD_W-1:0];
      expected_cells = {expected_cells, r};
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_result();
    grid_result_t want;
    if (expected_cells.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d (%0d,%0d,%0d)", kind,
                                x_half_steps, y_half_steps, z_half_steps));
      return;
    end
    want = expected_cells.pop_front();
    if (kind != want.kind)
      report_mismatch($sformatf("kind %0d, expected %s", kind, want.kind.name()));
    if (x_half_steps != want.x)
      report_mismatch($sformatf("x %0d, expected %0d", x_half_steps, want.x));
    if (y_half_steps != want.y)
      report_mismatch($sformatf("y %0d, expected %0d", y_half_steps, want.y));
    if (z_half_steps != want.z)
      report_mismatch($sformatf("z %0d, expected %0d", z_half_steps, want.z));
    case (want.kind)
      KIND_POINT: points_seen++;
      KIND_DONE: done_seen++;
      default: empty_seen++;
    endcase
  endtask

  // Outputs are stable from the falling edge to the rising edge that completes the transfer.
  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) check_result();
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sphere_grid_point_enumerator test failed");
    $finish;
  end

  task automatic send_item(input bit new_scan);
    int gap;
    bit taken;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart <= new_scan;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    predict_cell(new_scan);
    transfers_in++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    if (idx == CFG_GRID_STEPS) grid_steps_now = value;
    else symmetry_now = value[1:0];
  endtask

  task automatic configure(input int steps, input int mode);
    wait_drained();
    write_register(CFG_GRID_STEPS, steps[CFG_DATA_W-1:0]);
    write_register(CFG_SYMMETRY, {6'd0, mode[1:0]});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_idle_items();
    repeat (2) send_item(1'b0);
  endtask

  // With the reset grid of one step every cell misses the unit sphere.
  task automatic test_empty_scan();
    send_item(1'b1);
    repeat (8) send_item(1'b0);
  endtask

  task automatic test_zero_steps();
    configure(0, SYM_OCTANT);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
  endtask

  task automatic test_restart_mid_scan();
    configure(MAX_STEPS, SYM_UNUSED);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  // Shrinking the grid leaves the inner index past the new last cell.
  task automatic test_config_mid_scan();
    configure(2, SYM_FULL);
    send_item(1'b1);
    send_item(1'b0);
    configure(0, SYM_FULL);
    repeat (2) send_item(1'b0);
  endtask

  task automatic test_back_pressure();
    configure(4, SYM_FULL);
    @(negedge clk);
    hold_cycles = 300;
    @(posedge clk);
    send_item(1'b1);
    repeat (60) send_item(1'b0);
    wait_drained();
  endtask

  task automatic test_random_scans(input int n_items);
    int sent;
    int cells;
    int cell_cap;
    int steps;
    bit wide;
    sent = 0;
    while (sent < n_items) begin
      wide = ($urandom_range(0, 9) == 0);
      steps = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) steps = 4;
      if (wide) steps = $urandom_range(200, 255);
      configure(steps, $urandom_range(0, 3));
      send_item(1'b1);
      sent++;
      cell_cap = wide ? $urandom_range(5, 40) : CYCLE_LIMIT;
      cells = 0;
      while (scanning && cells < cell_cap) begin
        send_item($urandom_range(0, 59) == 0);
        sent++;
        cells++;
      end
      repeat ($urandom_range(0, 2)) send_item(1'b0);
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_idle_items();
    test_empty_scan();
    test_zero_steps();
    test_restart_mid_scan();
    test_config_mid_scan();
    test_random_scans(90);
    send_idle_pct = 75;
    recv_idle_pct = 36;
    test_random_scans(90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_back_pressure();
    test_random_scans(90);
    wait_drained();
    $display("Run covered %0d input transfers over grids of 0 to 255 steps in all symmetry codes.",
             transfers_in);
    $display("Checked %0d points, %0d done reports and %0d empty reports.",
             points_seen, done_seen, empty_seen);
    if (mismatches == 0) begin
      $display("sphere_grid_point_enumerator test passed");
    end else begin
      $display("sphere_grid_point_enumerator test failed");
    end
    $finish;
  end

endmodule
